@@ hw/rtl/bafu_pkg.sv @@
package bafu_pkg;

  localparam int unsigned CmdWidth   = 6;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned FlagWidth  = 6;
  localparam int unsigned InTdataW   = 16;
  localparam int unsigned OutTdataW  = 56;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 4;
  localparam int unsigned FLAG_N = 5;

  localparam logic [ByteWidth-1:0] SpReset = 8'hFF;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADC     = 6'd0,
    CMD_SBC     = 6'd1,
    CMD_AND     = 6'd2,
    CMD_ORA     = 6'd3,
    CMD_EOR     = 6'd4,
    CMD_BIT     = 6'd5,
    CMD_CMP     = 6'd6,
    CMD_CPX     = 6'd7,
    CMD_CPY     = 6'd8,
    CMD_ASL_A   = 6'd9,
    CMD_ASL_M   = 6'd10,
    CMD_LSR_A   = 6'd11,
    CMD_LSR_M   = 6'd12,
    CMD_ROL_A   = 6'd13,
    CMD_ROL_M   = 6'd14,
    CMD_ROR_A   = 6'd15,
    CMD_ROR_M   = 6'd16,
    CMD_INC     = 6'd17,
    CMD_DEC     = 6'd18,
    CMD_INX     = 6'd19,
    CMD_INY     = 6'd20,
    CMD_DEX     = 6'd21,
    CMD_DEY     = 6'd22,
    CMD_LDA     = 6'd23,
    CMD_LDX     = 6'd24,
    CMD_LDY     = 6'd25,
    CMD_TAX     = 6'd26,
    CMD_TAY     = 6'd27,
    CMD_TXA     = 6'd28,
    CMD_TYA     = 6'd29,
    CMD_TSX     = 6'd30,
    CMD_TXS     = 6'd31,
    CMD_CLC     = 6'd32,
    CMD_SEC     = 6'd33,
    CMD_CLD     = 6'd34,
    CMD_SED     = 6'd35,
    CMD_CLI     = 6'd36,
    CMD_SEI     = 6'd37,
    CMD_CLV     = 6'd38,
    CMD_BCC     = 6'd39,
    CMD_BCS     = 6'd40,
    CMD_BEQ     = 6'd41,
    CMD_BNE     = 6'd42,
    CMD_BMI     = 6'd43,
    CMD_BPL     = 6'd44,
    CMD_BVC     = 6'd45,
    CMD_BVS     = 6'd46,
    CMD_STA     = 6'd47,
    CMD_STX     = 6'd48,
    CMD_STY     = 6'd49,
    CMD_PHA     = 6'd50,
    CMD_PHP     = 6'd51,
    CMD_PLA     = 6'd52,
    CMD_PLP     = 6'd53
  } cmd_e;

  typedef struct packed {
    logic [ByteWidth-1:0] a;
    logic [ByteWidth-1:0] x;
    logic [ByteWidth-1:0] y;
    logic [ByteWidth-1:0] sp;
    logic [FlagWidth-1:0] flags;
  } cpu_state_t;

  typedef struct packed {
    logic [ByteWidth-1:0] mem_value;
    logic                 mem_write;
    logic                 branch_taken;
  } exec_result_t;

  function automatic logic [ByteWidth-1:0] pack_status(logic [FlagWidth-1:0] f);
    return {f[FLAG_N], f[FLAG_V], 1'b1, 1'b0, f[FLAG_D], f[FLAG_I], f[FLAG_Z], f[FLAG_C]};
  endfunction

endpackage

@@ hw/rtl/bafu_exec.sv @@
module bafu_exec (
  input  logic [bafu_pkg::CmdWidth-1:0]  command_i,
  input  logic [bafu_pkg::ByteWidth-1:0] operand_i,
  input  bafu_pkg::cpu_state_t           state_i,
  output bafu_pkg::cpu_state_t           state_o,
  output bafu_pkg::exec_result_t         result_o
);
  import bafu_pkg::*;

  cmd_e                 cmd;
  logic                 c_in;
  logic [8:0]           bin_sum;
  logic [7:0]           bin_b;
  logic [4:0]           dadd_lo;
  logic [4:0]           dadd_lo_adj;
  logic [9:0]           dadd_sum;
  logic [9:0]           dadd_adj;
  logic signed [5:0]    dsub_lo;
  logic [5:0]           dsub_lo_tmp;
  logic signed [5:0]    dsub_lo_adj;
  logic signed [10:0]   dsub_diff;
  logic signed [10:0]   dsub_adj;
  logic [8:0]           cmp_diff;
  logic [7:0]           cmp_reg;
  logic [7:0]           sh_src;
  logic [7:0]           sh_res;
  logic                 sh_cout;
  logic [7:0]           nz_val;
  logic                 nz_upd;

  assign cmd  = cmd_e'(command_i);
  assign c_in = state_i.flags[FLAG_C];

  // binary add; SBC adds the inverted operand
  assign bin_b   = (cmd == CMD_SBC) ? ~operand_i : operand_i;
  assign bin_sum = {1'b0, state_i.a} + {1'b0, bin_b} + {8'd0, c_in};

  // decimal add
  assign dadd_lo     = {1'b0, state_i.a[3:0]} + {1'b0, operand_i[3:0]} + {4'd0, c_in};
  assign dadd_lo_adj = (dadd_lo >= 5'h0A) ? {1'b1, 4'(dadd_lo[3:0] + 4'h6)} : dadd_lo;
  assign dadd_sum    = {2'b00, state_i.a[7:4], 4'h0} + {2'b00, operand_i[7:4], 4'h0}
                     + {5'd0, dadd_lo_adj};
  assign dadd_adj    = (dadd_sum >= 10'h0A0) ? dadd_sum + 10'h060 : dadd_sum;

  // decimal subtract
  assign dsub_lo     = $signed({2'b00, state_i.a[3:0]}) - $signed({2'b00, operand_i[3:0]})
                     - $signed({5'd0, ~c_in});
  assign dsub_lo_tmp = dsub_lo + 6'sd26;
  assign dsub_lo_adj = dsub_lo[5] ? $signed({2'b11, dsub_lo_tmp[3:0]}) : dsub_lo;
  assign dsub_diff   = $signed({3'b000, state_i.a[7:4], 4'h0})
                     - $signed({3'b000, operand_i[7:4], 4'h0})
                     + 11'(dsub_lo_adj);
  assign dsub_adj    = dsub_diff[10] ? dsub_diff - 11'sd96 : dsub_diff;

  // compares
  always_comb begin
    unique case (cmd)
      CMD_CPX: cmp_reg = state_i.x;
      CMD_CPY: cmp_reg = state_i.y;
      default: cmp_reg = state_i.a;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand_i};

  // shifts and rotates
  always_comb begin
    unique case (cmd)
      CMD_ASL_A, CMD_LSR_A, CMD_ROL_A, CMD_ROR_A: sh_src = state_i.a;
      default:                                    sh_src = operand_i;
    endcase
    unique case (cmd)
      CMD_ASL_A, CMD_ASL_M: begin
        sh_res  = {sh_src[6:0], 1'b0};
        sh_cout = sh_src[7];
      end
      CMD_ROL_A, CMD_ROL_M: begin
        sh_res  = {sh_src[6:0], c_in};
        sh_cout = sh_src[7];
      end
      CMD_ROR_A, CMD_ROR_M: begin
        sh_res  = {c_in, sh_src[7:1]};
        sh_cout = sh_src[0];
      end
      default: begin
        sh_res  = {1'b0, sh_src[7:1]};
        sh_cout = sh_src[0];
      end
    endcase
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    nz_val   = '0;
    nz_upd   = 1'b0;
    unique case (cmd)
      CMD_ADC: begin
        if (state_i.flags[FLAG_D]) begin
          state_o.a             = dadd_adj[7:0];
          state_o.flags[FLAG_C] = dadd_adj >= 10'h100;
          state_o.flags[FLAG_V] = dadd_adj > 10'd127;
        end else begin
          state_o.a             = bin_sum[7:0];
          state_o.flags[FLAG_C] = bin_sum[8];
          state_o.flags[FLAG_V] = ~(state_i.a[7] ^ bin_b[7]) & (bin_sum[7] ^ bin_b[7]);
        end
        nz_val = state_o.a;
        nz_upd = 1'b1;
      end
      CMD_SBC: begin
        if (state_i.flags[FLAG_D]) begin
          state_o.a             = dsub_adj[7:0];
          state_o.flags[FLAG_Z] = dsub_adj[7:0] == 8'd0;
          state_o.flags[FLAG_C] = ~dsub_diff[10];
        end else begin
          state_o.a             = bin_sum[7:0];
          state_o.flags[FLAG_C] = bin_sum[8];
          state_o.flags[FLAG_V] = ~(state_i.a[7] ^ bin_b[7]) & (bin_sum[7] ^ bin_b[7]);
          nz_val                = bin_sum[7:0];
          nz_upd                = 1'b1;
        end
      end
      CMD_AND: begin
        state_o.a = state_i.a & operand_i;
        nz_val    = state_o.a;
        nz_upd    = 1'b1;
      end
      CMD_ORA: begin
        state_o.a = state_i.a | operand_i;
        nz_val    = state_o.a;
        nz_upd    = 1'b1;
      end
      CMD_EOR: begin
        state_o.a = state_i.a ^ operand_i;
        nz_val    = state_o.a;
        nz_upd    = 1'b1;
      end
      CMD_BIT: begin
        state_o.flags[FLAG_Z] = (state_i.a & operand_i) == 8'd0;
        state_o.flags[FLAG_N] = operand_i[7];
        state_o.flags[FLAG_V] = operand_i[6];
      end
      CMD_CMP, CMD_CPX, CMD_CPY: begin
        state_o.flags[FLAG_C] = ~cmp_diff[8];
        state_o.flags[FLAG_Z] = cmp_reg == operand_i;
        state_o.flags[FLAG_N] = cmp_diff[7];
      end
      CMD_ASL_A, CMD_LSR_A, CMD_ROL_A, CMD_ROR_A: begin
        state_o.a             = sh_res;
        state_o.flags[FLAG_C] = sh_cout;
        nz_val                = sh_res;
        nz_upd                = 1'b1;
      end
      CMD_ASL_M, CMD_LSR_M, CMD_ROL_M, CMD_ROR_M: begin
        result_o.mem_value    = sh_res;
        result_o.mem_write    = 1'b1;
        state_o.flags[FLAG_C] = sh_cout;
        nz_val                = sh_res;
        nz_upd                = 1'b1;
      end
      CMD_INC: begin
        result_o.mem_value = operand_i + 8'd1;
        result_o.mem_write = 1'b1;
        nz_val             = result_o.mem_value;
        nz_upd             = 1'b1;
      end
      CMD_DEC: begin
        result_o.mem_value = operand_i - 8'd1;
        result_o.mem_write = 1'b1;
        nz_val             = result_o.mem_value;
        nz_upd             = 1'b1;
      end
      CMD_INX: begin
        state_o.x = state_i.x + 8'd1;
        nz_val    = state_o.x;
        nz_upd    = 1'b1;
      end
      CMD_INY: begin
        state_o.y = state_i.y + 8'd1;
        nz_val    = state_o.y;
        nz_upd    = 1'b1;
      end
      CMD_DEX: begin
        state_o.x = state_i.x - 8'd1;
        nz_val    = state_o.x;
        nz_upd    = 1'b1;
      end
      CMD_DEY: begin
        state_o.y = state_i.y - 8'd1;
        nz_val    = state_o.y;
        nz_upd    = 1'b1;
      end
      CMD_LDA, CMD_PLA: begin
        state_o.a = operand_i;
        nz_val    = operand_i;
        nz_upd    = 1'b1;
        if (cmd == CMD_PLA) begin
          state_o.sp = state_i.sp + 8'd1;
        end
      end
      CMD_LDX: begin
        state_o.x = operand_i;
        nz_val    = operand_i;
        nz_upd    = 1'b1;
      end
      CMD_LDY: begin
        state_o.y = operand_i;
        nz_val    = operand_i;
        nz_upd    = 1'b1;
      end
      CMD_TAX: begin
        state_o.x = state_i.a;
        nz_val    = state_i.a;
        nz_upd    = 1'b1;
      end
      CMD_TAY: begin
        state_o.y = state_i.a;
        nz_val    = state_i.a;
        nz_upd    = 1'b1;
      end
      CMD_TXA: begin
        state_o.a = state_i.x;
        nz_val    = state_i.x;
        nz_upd    = 1'b1;
      end
      CMD_TYA: begin
        state_o.a = state_i.y;
        nz_val    = state_i.y;
        nz_upd    = 1'b1;
      end
      CMD_TSX: begin
        state_o.x = state_i.sp;
        nz_val    = state_i.sp;
        nz_upd    = 1'b1;
      end
      CMD_TXS: state_o.sp = state_i.x;
      CMD_CLC: state_o.flags[FLAG_C] = 1'b0;
      CMD_SEC: state_o.flags[FLAG_C] = 1'b1;
      CMD_CLD: state_o.flags[FLAG_D] = 1'b0;
      CMD_SED: state_o.flags[FLAG_D] = 1'b1;
      CMD_CLI: state_o.flags[FLAG_I] = 1'b0;
      CMD_SEI: state_o.flags[FLAG_I] = 1'b1;
      CMD_CLV: state_o.flags[FLAG_V] = 1'b0;
      CMD_BCC: result_o.branch_taken = ~state_i.flags[FLAG_C];
      CMD_BCS: result_o.branch_taken =  state_i.flags[FLAG_C];
      CMD_BEQ: result_o.branch_taken =  state_i.flags[FLAG_Z];
      CMD_BNE: result_o.branch_taken = ~state_i.flags[FLAG_Z];
      CMD_BMI: result_o.branch_taken =  state_i.flags[FLAG_N];
      CMD_BPL: result_o.branch_taken = ~state_i.flags[FLAG_N];
      CMD_BVC: result_o.branch_taken = ~state_i.flags[FLAG_V];
      CMD_BVS: result_o.branch_taken =  state_i.flags[FLAG_V];
      CMD_STA: begin
        result_o.mem_value = state_i.a;
        result_o.mem_write = 1'b1;
      end
      CMD_STX: begin
        result_o.mem_value = state_i.x;
        result_o.mem_write = 1'b1;
      end
      CMD_STY: begin
        result_o.mem_value = state_i.y;
        result_o.mem_write = 1'b1;
      end
      CMD_PHA: begin
        result_o.mem_value = state_i.a;
        result_o.mem_write = 1'b1;
        state_o.sp         = state_i.sp - 8'd1;
      end
      CMD_PHP: begin
        result_o.mem_value = pack_status(state_i.flags) | 8'h30;
        result_o.mem_write = 1'b1;
        state_o.sp         = state_i.sp - 8'd1;
      end
      CMD_PLP: begin
        state_o.sp    = state_i.sp + 8'd1;
        state_o.flags = {operand_i[7], operand_i[6], operand_i[3:0]};
      end
      default: ;
    endcase
    if (nz_upd) begin
      state_o.flags[FLAG_N] = nz_val[7];
      state_o.flags[FLAG_Z] = nz_val == 8'd0;
    end
  end

endmodule

@@ hw/rtl/byte_alu_bcd_flags_unit_core.sv @@
// channel   dir  width  contents
// s_axis    in   16     command, operand
// m_axis    out  56     reg_a, reg_x, reg_y, reg_sp, status, mem_value, mem_write, branch_taken
//
// One word per cycle; a result appears on m_axis the cycle after its word is taken.
// Register file and flags update at the accepting edge, so each word sees the last one's state.
// The single output register sets the rate: s_axis stalls only while that register is full
// and m_axis_tready_i is low.
// Reset: A, X, Y, flags clear, stack pointer to 0xFF, output empty.
module byte_alu_bcd_flags_unit_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [5:0] command, [13:6] operand, [15:14] zero
  input  logic [bafu_pkg::InTdataW-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [7:0] reg_a, [15:8] reg_x, [23:16] reg_y, [31:24] reg_sp, [39:32] status,
  // [47:40] mem_value, [48] mem_write, [49] branch_taken, [55:50] zero
  output logic [bafu_pkg::OutTdataW-1:0]    m_axis_tdata_o
);
  import bafu_pkg::*;

  cpu_state_t             state_q, state_d;
  exec_result_t           exec_res;
  logic                   out_valid_q, out_valid_d;
  logic [OutTdataW-1:0]   out_data_q, out_data_d;
  logic                   in_fire;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  bafu_exec u_exec (
    .command_i (s_axis_tdata_i[5:0]),
    .operand_i (s_axis_tdata_i[13:6]),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (exec_res)
  );

  assign out_data_d = {6'd0, exec_res.branch_taken, exec_res.mem_write, exec_res.mem_value,
                       pack_status(state_d.flags), state_d.sp, state_d.y, state_d.x, state_d.a};

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{a: '0, x: '0, y: '0, sp: SpReset, flags: '0};
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while output register can take a word");

  a_word_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");

  a_status_fixed_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[37:36] == 2'b10))
    else $error("status bits 5 and 4 wrong");

  a_mem_value_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[48]) |-> (m_axis_tdata_o[47:40] == 8'd0))
    else $error("mem_value nonzero without mem_write");

  a_no_write_and_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[48] && m_axis_tdata_o[49]))
    else $error("write and branch in one word");

endmodule

@@ tb/byte_alu_bcd_flags_unit_core_tb.sv @@
module byte_alu_bcd_flags_unit_core_tb;
  import bafu_pkg::*;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned StallCycles = 300;
  localparam int unsigned DrainCycles = 8;

  localparam logic [CmdWidth-1:0] CmdUnusedLo = 6'd54;
  localparam logic [CmdWidth-1:0] CmdUnusedHi = 6'd63;

  localparam logic [1:0] ShAsl = 2'd0;
  localparam logic [1:0] ShLsr = 2'd1;
  localparam logic [1:0] ShRol = 2'd2;
  localparam logic [1:0] ShRor = 2'd3;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // [5:0] command, [13:6] operand, [15:14] zero
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // [7:0] reg_a, [15:8] reg_x, [23:16] reg_y, [31:24] reg_sp, [39:32] status,
  // [47:40] mem_value, [48] mem_write, [49] branch_taken, [55:50] zero
  logic [OutTdataW-1:0] m_axis_tdata_o;

  byte_alu_bcd_flags_unit_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  logic [ByteWidth-1:0] mdl_a     = '0;
  logic [ByteWidth-1:0] mdl_x     = '0;
  logic [ByteWidth-1:0] mdl_y     = '0;
  logic [ByteWidth-1:0] mdl_sp    = SpReset;
  logic [FlagWidth-1:0] mdl_flags = '0;
  logic [OutTdataW-1:0] exp_results[$];

  int unsigned errors        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_asked   = 0;
  int unsigned stall_taken   = 0;
  int unsigned stall_left    = 0;
  int unsigned cycle_cnt     = 0;

  function automatic void set_nz(logic [7:0] v);
    mdl_flags[FLAG_N] = v[7];
    mdl_flags[FLAG_Z] = (v == 8'h00);
  endfunction

  function automatic logic [7:0] status_byte(logic brk_bits);
    return {mdl_flags[FLAG_N], mdl_flags[FLAG_V], 1'b1, brk_bits,
            mdl_flags[FLAG_D], mdl_flags[FLAG_I], mdl_flags[FLAG_Z], mdl_flags[FLAG_C]};
  endfunction

  function automatic void add_binary(logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, mdl_a} + {1'b0, b} + {8'h00, mdl_flags[FLAG_C]};
    mdl_flags[FLAG_C] = sum[8];
    mdl_flags[FLAG_V] = (mdl_a[7] == b[7]) && (sum[7] != b[7]);
    mdl_a = sum[7:0];
    set_nz(mdl_a);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] b);
    logic [7:0] diff;
    diff = r - b;
    mdl_flags[FLAG_C] = (r >= b);
    mdl_flags[FLAG_Z] = (r == b);
    mdl_flags[FLAG_N] = diff[7];
  endfunction

  function automatic logic [7:0] shift_byte(logic [1:0] kind, logic [7:0] d);
    logic [7:0] r;
    logic       cin;
    cin = mdl_flags[FLAG_C];
    case (kind)
      ShAsl: begin
        r = {d[6:0], 1'b0};
        mdl_flags[FLAG_C] = d[7];
      end
      ShLsr: begin
        r = {1'b0, d[7:1]};
        mdl_flags[FLAG_C] = d[0];
      end
      ShRol: begin
        r = {d[6:0], cin};
        mdl_flags[FLAG_C] = d[7];
      end
      default: begin
        r = {cin, d[7:1]};
        mdl_flags[FLAG_C] = d[0];
      end
    endcase
    set_nz(r);
    return r;
  endfunction

  task automatic predict_exec(input logic [CmdWidth-1:0] cmd, input logic [7:0] opnd);
    logic [7:0] wval;
    logic       wr;
    logic       br;
    int         lo;
    int         sum;
    wval = '0;
    wr   = 1'b0;
    br   = 1'b0;
    case (cmd)
      CMD_ADC: begin
        if (mdl_flags[FLAG_D]) begin
          lo = int'(mdl_a[3:0]) + int'(opnd[3:0]) + int'(mdl_flags[FLAG_C]);
          if (lo >= 10) lo = ((lo + 6) & 15) + 16;
          sum = int'({mdl_a[7:4], 4'h0}) + int'({opnd[7:4], 4'h0}) + lo;
          if (sum >= 'hA0) sum += 'h60;
          mdl_a = sum[7:0];
          set_nz(mdl_a);
          mdl_flags[FLAG_C] = (sum >= 'h100);
          mdl_flags[FLAG_V] = (sum > 127);
        end else begin
          add_binary(opnd);
        end
      end
      CMD_SBC: begin
        if (mdl_flags[FLAG_D]) begin
          lo = int'(mdl_a[3:0]) - int'(opnd[3:0]) - (mdl_flags[FLAG_C] ? 0 : 1);
          if (lo < 0) lo = ((lo - 6 + 32) & 15) - 16;
          sum = int'({mdl_a[7:4], 4'h0}) - int'({opnd[7:4], 4'h0}) + lo;
          if (sum < 0) sum -= 'h60;
          mdl_a = sum[7:0];
          mdl_flags[FLAG_Z] = (mdl_a == 8'h00);
          mdl_flags[FLAG_C] = (sum >= 0);
        end else begin
          add_binary(~opnd);
        end
      end
      CMD_AND: begin
        mdl_a = mdl_a & opnd;
        set_nz(mdl_a);
      end
      CMD_ORA: begin
        mdl_a = mdl_a | opnd;
        set_nz(mdl_a);
      end
      CMD_EOR: begin
        mdl_a = mdl_a ^ opnd;
        set_nz(mdl_a);
      end
      CMD_BIT: begin
        mdl_flags[FLAG_Z] = ((mdl_a & opnd) == 8'h00);
        mdl_flags[FLAG_N] = opnd[7];
        mdl_flags[FLAG_V] = opnd[6];
      end
      CMD_CMP: compare_reg(mdl_a, opnd);
      CMD_CPX: compare_reg(mdl_x, opnd);
      CMD_CPY: compare_reg(mdl_y, opnd);
      CMD_ASL_A: mdl_a = shift_byte(ShAsl, mdl_a);
      CMD_LSR_A: mdl_a = shift_byte(ShLsr, mdl_a);
      CMD_ROL_A: mdl_a = shift_byte(ShRol, mdl_a);
      CMD_ROR_A: mdl_a = shift_byte(ShRor, mdl_a);
      CMD_ASL_M: begin
        wval = shift_byte(ShAsl, opnd);
        wr   = 1'b1;
      end
      CMD_LSR_M: begin
        wval = shift_byte(ShLsr, opnd);
        wr   = 1'b1;
      end
      CMD_ROL_M: begin
        wval = shift_byte(ShRol, opnd);
        wr   = 1'b1;
      end
      CMD_ROR_M: begin
        wval = shift_byte(ShRor, opnd);
        wr   = 1'b1;
      end
      CMD_INC: begin
        wval = opnd + 8'h01;
        set_nz(wval);
        wr = 1'b1;
      end
      CMD_DEC: begin
        wval = opnd - 8'h01;
        set_nz(wval);
        wr = 1'b1;
      end
      CMD_INX: begin
        mdl_x = mdl_x + 8'h01;
        set_nz(mdl_x);
      end
      CMD_INY: begin
        mdl_y = mdl_y + 8'h01;
        set_nz(mdl_y);
      end
      CMD_DEX: begin
        mdl_x = mdl_x - 8'h01;
        set_nz(mdl_x);
      end
      CMD_DEY: begin
        mdl_y = mdl_y - 8'h01;
        set_nz(mdl_y);
      end
      CMD_LDA: begin
        mdl_a = opnd;
        set_nz(mdl_a);
      end
      CMD_LDX: begin
        mdl_x = opnd;
        set_nz(mdl_x);
      end
      CMD_LDY: begin
        mdl_y = opnd;
        set_nz(mdl_y);
      end
      CMD_TAX: begin
        mdl_x = mdl_a;
        set_nz(mdl_x);
      end
      CMD_TAY: begin
        mdl_y = mdl_a;
        set_nz(mdl_y);
      end
      CMD_TXA: begin
        mdl_a = mdl_x;
        set_nz(mdl_a);
      end
      CMD_TYA: begin
        mdl_a = mdl_y;
        set_nz(mdl_a);
      end
      CMD_TSX: begin
        mdl_x = mdl_sp;
        set_nz(mdl_x);
      end
      CMD_TXS: mdl_sp = mdl_x;
      CMD_CLC: mdl_flags[FLAG_C] = 1'b0;
      CMD_SEC: mdl_flags[FLAG_C] = 1'b1;
      CMD_CLD: mdl_flags[FLAG_D] = 1'b0;
      CMD_SED: mdl_flags[FLAG_D] = 1'b1;
      CMD_CLI: mdl_flags[FLAG_I] = 1'b0;
      CMD_SEI: mdl_flags[FLAG_I] = 1'b1;
      CMD_CLV: mdl_flags[FLAG_V] = 1'b0;
      CMD_BCC: br = !mdl_flags[FLAG_C];
      CMD_BCS: br = mdl_flags[FLAG_C];
      CMD_BEQ: br = mdl_flags[FLAG_Z];
      CMD_BNE: br = !mdl_flags[FLAG_Z];
      CMD_BMI: br = mdl_flags[FLAG_N];
      CMD_BPL: br = !mdl_flags[FLAG_N];
      CMD_BVC: br = !mdl_flags[FLAG_V];
      CMD_BVS: br = mdl_flags[FLAG_V];
      CMD_STA: begin
        wval = mdl_a;
        wr   = 1'b1;
      end
      CMD_STX: begin
        wval = mdl_x;
        wr   = 1'b1;
      end
      CMD_STY: begin
        wval = mdl_y;
        wr   = 1'b1;
      end
      CMD_PHA: begin
        wval   = mdl_a;
        wr     = 1'b1;
        mdl_sp = mdl_sp - 8'h01;
      end
      CMD_PHP: begin
        wval   = status_byte(1'b1);
        wr     = 1'b1;
        mdl_sp = mdl_sp - 8'h01;
      end
      CMD_PLA: begin
        mdl_sp = mdl_sp + 8'h01;
        mdl_a  = opnd;
        set_nz(mdl_a);
      end
      CMD_PLP: begin
        mdl_sp = mdl_sp + 8'h01;
        mdl_flags[FLAG_N] = opnd[7];
        mdl_flags[FLAG_V] = opnd[6];
        mdl_flags[FLAG_D] = opnd[3];
        mdl_flags[FLAG_I] = opnd[2];
        mdl_flags[FLAG_Z] = opnd[1];
        mdl_flags[FLAG_C] = opnd[0];
      end
      default: ;
    endcase
    exp_results.push_back({6'b000000, br, wr, wval, status_byte(1'b0),
                           mdl_sp, mdl_y, mdl_x, mdl_a});
  endtask

  task automatic send_word(input logic [CmdWidth-1:0] cmd, input logic [7:0] opnd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= InTdataW'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, opnd, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_exec(cmd, opnd);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'hFF;
          2: return 8'h7F;
          default: return 8'h80;
        endcase
      end
      1: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random();
    send_word(CmdWidth'($urandom_range(0, 63)), pick_operand());
  endtask

  task automatic test_reset_state();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    send_word(CmdUnusedLo, 8'h00);
    send_word(CmdUnusedHi, 8'hFF);
  endtask

  task automatic test_stack_wrap();
    send_word(CMD_PLA, 8'h00);
    send_word(CMD_PHP, 8'hFF);
    send_word(CMD_PHA, 8'h5A);
    send_word(CMD_PLP, 8'hFF);
  endtask

  task automatic test_decimal();
    send_word(CMD_SED, 8'h00);
    send_word(CMD_CLC, 8'h00);
    send_word(CMD_LDA, 8'h99);
    send_word(CMD_ADC, 8'h01);
    send_word(CMD_ADC, 8'h99);
    send_word(CMD_SEC, 8'h00);
    send_word(CMD_LDA, 8'h00);
    send_word(CMD_SBC, 8'h01);
    send_word(CMD_SBC, 8'hFF);
    send_word(CMD_CLD, 8'h00);
  endtask

  task automatic test_binary_extremes();
    send_word(CMD_CLC, 8'h00);
    send_word(CMD_LDA, 8'h7F);
    send_word(CMD_ADC, 8'h01);
    send_word(CMD_SBC, 8'h80);
    send_word(CMD_BIT, 8'hC0);
    send_word(CMD_CMP, 8'hFF);
    send_word(CMD_ASL_A, 8'h00);
    send_word(CMD_ROR_M, 8'h01);
    send_word(CMD_INC, 8'hFF);
    send_word(CMD_DEC, 8'h00);
    send_word(CMD_BVS, 8'h00);
    send_word(CMD_BMI, 8'h00);
  endtask

  task automatic test_each_command();
    for (int c = 0; c < 64; c++) send_word(CmdWidth'(c), pick_operand());
  endtask

  task automatic test_random(input int unsigned n, input int unsigned s_pct,
                             input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_random();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asked   = stall_asked + 1;
    repeat (40) send_random();
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    logic [OutTdataW-1:0] want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_results.size() == 0) begin
        $display("%0t: word expected none actual %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        want = exp_results.pop_front();
        check_field("reg_a", want[7:0], m_axis_tdata_o[7:0]);
        check_field("reg_x", want[15:8], m_axis_tdata_o[15:8]);
        check_field("reg_y", want[23:16], m_axis_tdata_o[23:16]);
        check_field("reg_sp", want[31:24], m_axis_tdata_o[31:24]);
        check_field("status", want[39:32], m_axis_tdata_o[39:32]);
        check_field("mem_value", want[47:40], m_axis_tdata_o[47:40]);
        check_field("mem_write", {7'b0, want[48]}, {7'b0, m_axis_tdata_o[48]});
        check_field("branch_taken", {7'b0, want[49]}, {7'b0, m_axis_tdata_o[49]});
        check_field("pad", {2'b0, want[55:50]}, {2'b0, m_axis_tdata_o[55:50]});
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (stall_taken != stall_asked) begin
      m_axis_tready_i <= 1'b0;
      stall_taken     <= stall_asked;
      stall_left      <= StallCycles;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_stack_wrap();
    test_decimal();
    test_binary_extremes();
    test_each_command();
    test_random(523, 30, 67);
    test_backpressure();
    test_random(523, 67, 30);
    test_random(522, 0, 0);
    drain_results();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
